/* hw/rtl/deq_pkg.sv */
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH   = 16;
  localparam int FUNC_W      = 3;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int POSITION_W  = 4;
  localparam int COUNT_W     = 5;

  // input function codes
  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd4;
  localparam logic [FUNC_W-1:0] FN_FIND       = 3'd5;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_CLEAR,
    OP_FIND,
    OP_NOP
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    BK_IDLE,
    BK_FIND
  } back_state_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

endpackage

/* hw/rtl/double_ended_queue_with_search.sv */
// ----------------------------------------------------------------------------
// double_ended_queue_with_search
// Bounded deque of 32-bit values in a ring store, with a linear search
// from the front. One result transaction per input transaction.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_func, in_value
//   out_     output     out_valid/out_stall  out_status, out_position, out_count
//
// Push, pop, clear and unused codes complete in the executor's idle state.
// Find scans one entry per cycle through the store's single read port:
// the scan ends at the first match, or at the last occupied entry if none.
// A two-entry command queue sits between decode and execute.
// Reset clears pointers and counts; the store itself is not cleared.
// Output stall holds the result register and, once the queue fills, in_stall.
// ----------------------------------------------------------------------------
module double_ended_queue_with_search
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic [POSITION_W-1:0]      out_position,
  output logic [COUNT_W-1:0]         out_count
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  deq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_func   (in_func),
    .in_value  (in_value),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_position (out_position),
    .out_count    (out_count)
  );

endmodule

/* hw/rtl/deq_front.sv */
// ----------------------------------------------------------------------------
// deq_front
// Accepts input transactions, decodes the function code and holds the
// decoded commands in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module deq_front
  import deq_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [FUNC_W-1:0]          in_func,
  input  logic signed [VALUE_W-1:0]  in_value,
  output logic                       cmd_valid,
  output cmd_t                       cmd,
  input  logic                       cmd_take
);

  cmd_t       queue_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  cmd_t       decoded;

  always_comb begin
    decoded.value = in_value;
    unique case (in_func)
      FN_PUSH_FRONT: decoded.op = OP_PUSH_FRONT;
      FN_PUSH_BACK:  decoded.op = OP_PUSH_BACK;
      FN_POP_FRONT:  decoded.op = OP_POP_FRONT;
      FN_POP_BACK:   decoded.op = OP_POP_BACK;
      FN_CLEAR:      decoded.op = OP_CLEAR;
      FN_FIND:       decoded.op = OP_FIND;
      default:       decoded.op = OP_NOP;
    endcase
  end

  assign in_stall  = (cnt_r == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = cmd_take ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, cmd_take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= decoded;
    end
  end

endmodule

/* hw/rtl/deq_back.sv */
// ----------------------------------------------------------------------------
// deq_back
// Executes queued commands on the ring store: pushes, pops, clear and a
// linear search that reads one entry per cycle. Drives the result register.
// ----------------------------------------------------------------------------
module deq_back
  import deq_pkg::*;
#(
  parameter int DEPTH = DEQ_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    out_status,
  output logic [POSITION_W-1:0]  out_position,
  output logic [COUNT_W-1:0]     out_count
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  logic [VALUE_W-1:0] mem [DEPTH];

  back_state_t        state_r, state_nxt;
  logic [IW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      occ_r, occ_nxt;
  logic [CW-1:0]      iss_r, iss_nxt;
  logic [CW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [VALUE_W-1:0] rd_data_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [POSITION_W-1:0] out_pos_r, out_pos_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [IW-1:0]      rd_addr;
  logic               out_free;
  logic               full;
  logic               empty;
  logic [IW-1:0]      front_dec;
  logic [IW-1:0]      front_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign full      = (occ_r >= CW'(DEPTH));
  assign empty     = (occ_r == '0);
  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign rd_addr   = ring_slot(front_r, iss_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free && cmd.op == OP_FIND && !empty) begin
          state_nxt = BK_FIND;
        end
      end
      BK_FIND: begin
        if (cmp_vld_r && ((rd_data_r == key_r) || (cmp_idx_r == occ_r - 1'b1))) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_take       = 1'b0;
    front_nxt      = front_r;
    occ_nxt        = occ_r;
    iss_nxt        = iss_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    key_nxt        = key_r;
    wr_en          = 1'b0;
    wr_addr        = front_dec;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_pos_nxt    = out_pos_r;
    out_count_nxt  = out_count_r;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_take       = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_pos_nxt    = '0;
          unique case (cmd.op)
            OP_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = front_dec;
                front_nxt = front_dec;
                occ_nxt   = occ_r + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = ring_slot(front_r, occ_r);
                occ_nxt = occ_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                front_nxt = front_inc;
                occ_nxt   = occ_r - 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                occ_nxt = occ_r - 1'b1;
              end
            end
            OP_CLEAR: begin
              front_nxt = '0;
              occ_nxt   = '0;
            end
            OP_FIND: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                // result comes from the scan
                out_valid_nxt = 1'b0;
                key_nxt       = cmd.value;
                iss_nxt       = '0;
              end
            end
            default: ;
          endcase
          out_count_nxt = COUNT_W'(occ_nxt);
        end
      end
      BK_FIND: begin
        // issue one read per cycle; compare the data read last cycle
        if (iss_r < occ_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = iss_r;
          iss_nxt     = iss_r + 1'b1;
        end
        if (cmp_vld_r) begin
          if (rd_data_r == key_r) begin
            cmp_vld_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_pos_nxt    = POSITION_W'(cmp_idx_r);
            out_count_nxt  = COUNT_W'(occ_r);
          end else if (cmp_idx_r == occ_r - 1'b1) begin
            cmp_vld_nxt    = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOT_FOUND;
            out_pos_nxt    = '0;
            out_count_nxt  = COUNT_W'(occ_r);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      front_r     <= '0;
      occ_r       <= '0;
      iss_r       <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      occ_r       <= occ_nxt;
      iss_r       <= iss_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_pos_r    <= out_pos_nxt;
    out_count_r  <= out_count_nxt;
  end

  // entry store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_pos_r;
  assign out_count    = out_count_r;

endmodule
